// ----- rtl/ffba_pkg.sv -----
`timescale 1ns / 1ps
// Package for the first-fit block allocator: item types, command and
// status codes, sequencer states and default sizes. No dependencies.
package ffba_pkg;

    // Default sizing
    localparam int POOL_DEPTH_DEF = 1024;
    localparam int WORD_BYTES_DEF = 8;
    localparam int MIN_POOL_WORDS = 8;
    localparam logic [10:0] POOL_WORDS_RST = 11'd1024;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADOFF  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd        cmd;
        logic [13:0] size_bytes;
        logic [9:0]  payload_offset;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [9:0]  payload_word;
        logic [13:0] max_free_bytes;
    } t_out_item;

    // Handshake between the front end and the walking core
    typedef struct packed {
        logic start;
        logic take;
    } t_core_req;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_rsp;

    typedef enum logic [3:0] {
        S_FMT,
        S_IDLE,
        S_RD,
        S_HDR,
        S_MRD,
        S_MHDR,
        S_MWR,
        S_SPLIT,
        S_FRD,
        S_FWR,
        S_DONE
    } t_state;

endpackage

// ----- rtl/ffba_core.sv -----
`timescale 1ns / 1ps
// Header memory and walking sequencer of the allocator. One shared adder
// steps through block headers. Depends on ffba_pkg.
module ffba_core #(
    parameter int POOL_DEPTH = ffba_pkg::POOL_DEPTH_DEF,
    parameter int WORD_BYTES = ffba_pkg::WORD_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [10:0]         i_pool_words,
    input  ffba_pkg::t_in_item  i_item,
    input  ffba_pkg::t_core_req i_req,
    output ffba_pkg::t_core_rsp o_rsp,
    output ffba_pkg::t_out_item o_res
);
    import ffba_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int PW = AW + 1;
    localparam int RW = 15;
    localparam int RST_END = (int'(POOL_WORDS_RST) > POOL_DEPTH) ? POOL_DEPTH
                                                                  : int'(POOL_WORDS_RST);

    // Header memory: {size in words, used}. Walks read only block headers reachable
    // from word 1, so stale words need no clearing for a walk.
    logic [AW:0] mem [POOL_DEPTH];
    logic [AW:0] r_rdata;
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [AW:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    t_state    r_state, n_state;
    t_cmd      r_cmd, n_cmd;
    logic [RW-1:0] r_req, n_req;
    logic [9:0] r_off, n_off;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_end, n_end;
    logic [AW-1:0] r_size, n_size;
    logic [AW-1:0] r_best, n_best;
    logic       r_fmt_res, n_fmt_res;
    t_out_item  r_res, n_res;

    logic [AW-1:0] rd_size;
    logic          rd_used;
    logic [PW-1:0] add_a, sum;
    logic [AW-1:0] add_b;
    logic [PW-1:0] cfg_end;
    logic [31:0]   req_full, best_bytes, pay_full;
    logic          fits, splits;

    assign rd_size = r_rdata[AW:1];
    assign rd_used = r_rdata[0];

    // Shared adder: a + 1 + b
    assign sum = add_a + PW'(1) + PW'(add_b);

    // Pool end latched at init, saturated into the legal range
    always_comb begin
        if (int'(i_pool_words) < MIN_POOL_WORDS) begin
            cfg_end = PW'(MIN_POOL_WORDS);
        end else if (int'(i_pool_words) > POOL_DEPTH) begin
            cfg_end = PW'(POOL_DEPTH);
        end else begin
            cfg_end = PW'(i_pool_words);
        end
    end

    assign req_full   = (32'(i_item.size_bytes) + 32'(WORD_BYTES - 1)) / WORD_BYTES;
    assign best_bytes = 32'(r_best) * 32'(WORD_BYTES);
    assign pay_full   = 32'(r_pos) + 32'd1;
    assign fits       = 32'(r_size) >= 32'(r_req);
    assign splits     = 32'(r_size) >= 32'(r_req) + 32'd1;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FMT;
            r_end     <= PW'(RST_END);
            r_fmt_res <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_end     <= n_end;
            r_fmt_res <= n_fmt_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_req  <= n_req;
        r_off  <= n_off;
        r_pos  <= n_pos;
        r_size <= n_size;
        r_best <= n_best;
        r_res  <= n_res;
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_req     = r_req;
        n_off     = r_off;
        n_pos     = r_pos;
        n_end     = r_end;
        n_size    = r_size;
        n_best    = r_best;
        n_fmt_res = r_fmt_res;
        n_res     = r_res;
        add_a     = r_pos;
        add_b     = r_size;
        wr_en     = 1'b0;
        wr_addr   = r_pos[AW-1:0];
        wr_data   = '0;
        rd_addr   = r_pos[AW-1:0];
        case (r_state)
            S_FMT: begin
                wr_en   = 1'b1;
                wr_addr = AW'(1);
                wr_data = {AW'(r_end - PW'(2)), 1'b0};
                n_state = r_fmt_res ? S_DONE : S_IDLE;
            end
            S_IDLE: begin
                if (i_req.start) begin
                    n_cmd     = i_item.cmd;
                    n_req     = RW'(req_full);
                    n_off     = i_item.payload_offset;
                    n_pos     = PW'(1);
                    n_best    = '0;
                    n_fmt_res = 1'b0;
                    n_res     = '{status: ST_OK, payload_word: '0, max_free_bytes: '0};
                    case (i_item.cmd)
                        CMD_INIT: begin
                            n_end     = cfg_end;
                            n_fmt_res = 1'b1;
                            n_state   = S_FMT;
                        end
                        CMD_FREE: begin
                            if (i_item.payload_offset < 10'd2 ||
                                32'(i_item.payload_offset) - 32'd1 >= 32'(r_end)) begin
                                n_res.status = ST_BADOFF;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_FRD;
                            end
                        end
                        default: n_state = S_RD;
                    endcase
                end
            end
            // Fetch header at the walk position, or finish at the pool end
            S_RD: begin
                if (r_pos >= r_end) begin
                    if (r_cmd == CMD_ALLOC) begin
                        n_res.status = ST_NOSPACE;
                    end else begin
                        n_res.max_free_bytes = best_bytes[13:0];
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                add_b = rd_size;
                if (rd_used) begin
                    n_pos   = sum;
                    n_state = S_RD;
                end else begin
                    n_size  = rd_size;
                    n_state = S_MRD;
                end
            end
            // Look at the block after the free run
            S_MRD: begin
                rd_addr = sum[AW-1:0];
                n_state = (sum >= r_end) ? S_MWR : S_MHDR;
            end
            S_MHDR: begin
                add_a = PW'(r_size);
                add_b = rd_size;
                if (rd_used) begin
                    n_state = S_MWR;
                end else begin
                    n_size  = sum[AW-1:0];
                    n_state = S_MRD;
                end
            end
            // Store merged header; mark it used when it is chosen
            S_MWR: begin
                wr_en = 1'b1;
                if (r_cmd == CMD_ALLOC && fits) begin
                    wr_data = splits ? {AW'(r_req), 1'b1} : {r_size, 1'b1};
                    n_res.payload_word = pay_full[9:0];
                    n_state = splits ? S_SPLIT : S_DONE;
                end else begin
                    wr_data = {r_size, 1'b0};
                    if (r_size > r_best) begin
                        n_best = r_size;
                    end
                    n_pos   = sum;
                    n_state = S_RD;
                end
            end
            // Header of the remainder after a split
            S_SPLIT: begin
                add_b   = AW'(r_req);
                wr_en   = 1'b1;
                wr_addr = sum[AW-1:0];
                wr_data = {AW'(r_size - AW'(r_req) - AW'(1)), 1'b0};
                n_state = S_DONE;
            end
            S_FRD: begin
                rd_addr = AW'(r_off - 10'd1);
                n_state = S_FWR;
            end
            S_FWR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_off - 10'd1);
                wr_data = {rd_size, 1'b0};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_req.take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rsp.idle = (r_state == S_IDLE);
    assign o_rsp.done = (r_state == S_DONE);
    assign o_res      = r_res;

endmodule

// ----- rtl/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// First-fit allocator over an implicit list of block headers held in an
// on-chip memory. An allocate or query walks the headers, stepping over
// used blocks and merging each free run it reaches with the free blocks
// that follow it; the header walk sets the time. A free reads and rewrites
// one header, unless the offset is outside the pool; init rewrites the pool
// header. After reset the pool header is written before the first item is
// taken. Depends on ffba_pkg, ffba_core.
module first_fit_block_allocator #(
    parameter int POOL_DEPTH = ffba_pkg::POOL_DEPTH_DEF,
    parameter int WORD_BYTES = ffba_pkg::WORD_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ffba_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ffba_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [10:0]         i_cfg_data
);
    import ffba_pkg::*;

    logic [10:0] r_pool_words;
    logic        r_out_valid;
    t_out_item   r_out;
    t_core_req   req;
    t_core_rsp   rsp;
    t_out_item   core_res;
    logic        slot_free;

    // Pool size register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_words <= POOL_WORDS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pool_words <= i_cfg_data;
        end
    end

    // Input side: an item starts only when the core is idle
    assign o_in_stall = !rsp.idle;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign req.start  = i_in_valid && !o_in_stall;
    assign req.take   = rsp.done && slot_free;

    ffba_core #(
        .POOL_DEPTH(POOL_DEPTH),
        .WORD_BYTES(WORD_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pool_words (r_pool_words),
        .i_item       (i_in_item),
        .i_req        (req),
        .o_rsp        (rsp),
        .o_res        (core_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req.take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.take) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A failed item never carries a payload index
    a_fail_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.payload_word == 10'd0)
        else $error("failed item carries a payload index");

    // Once an item is taken the core is busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepting an item");

endmodule
